/* rtl/command_replay_dedup_table_macros.svh */
// assertion macros shared by the replay table checkers
// no dependencies; included by the checker file
`ifndef COMMAND_REPLAY_DEDUP_TABLE_MACROS_SVH
`define COMMAND_REPLAY_DEDUP_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CRDT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("crdt: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define CRDT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("crdt: next-cycle check failed");

`endif

/* rtl/crdt_pkg.sv */
// shared types and constants of the command replay dedup table
// no dependencies; imported by the top level, controller, datapath and checker
`default_nettype none

package crdt_pkg;

	localparam int ENTRIES_DEF = 64;
	localparam int OP_W        = 2;
	localparam int OWNER_W     = 16;
	localparam int CMDID_W     = 32;
	localparam int TICK_W      = 32;
	localparam int STATUS_W    = 3;
	localparam int COUNT_W     = 7;
	localparam int S_DATA_W    = 80;
	localparam int M_DATA_W    = 16;

	typedef enum logic [OP_W-1:0] {
		OP_REMEMBER = 2'd0,
		OP_CONTAINS = 2'd1,
		OP_EXPIRE   = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INVALID   = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_RECORDED  = 3'd2,
		ST_FULL      = 3'd3,
		ST_DONE      = 3'd4
	} status_t;

	// one table row as stored in the memory
	typedef struct packed {
		logic               valid;
		logic [TICK_W-1:0]  tick;
		logic [CMDID_W-1:0] cmd_id;
		logic [OWNER_W-1:0] owner;
	} entry_t;

	localparam int ENTRY_W = 1 + TICK_W + CMDID_W + OWNER_W;

	typedef enum logic [2:0] {
		CS_INIT,
		CS_IDLE,
		CS_SCAN,
		CS_CLEAR,
		CS_WRITE,
		CS_RESP
	} ctrl_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic scan_en;
		logic sweep_en;
		logic write_new;
		logic respond;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		op_t  op;
		logic id_absent;
		logic dup;
		logic free_found;
		logic scan_done;
		logic sweep_done;
		logic out_busy;
	} dp_stat_t;

endpackage

`default_nettype wire

/* rtl/command_replay_dedup_table.sv */
// command replay dedup table, top level; one command at a time; contains, remember and
// expire scan the whole table through the single read port of the table ram, clear all
// sweeps it through the write port; the next item is taken only after the result of the
// last one has been loaded into the output register, which waits while a result is unread
// reset: arst_n clears control state, then a clearing pass empties the table with
// s_axis_tready low; depends on crdt_pkg, crdt_ctrl and crdt_dpath
`default_nettype none

module command_replay_dedup_table import crdt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	// owner_id [15:0], command_id [47:16], tick [79:48]
	input  wire logic [S_DATA_W-1:0] s_axis_tdata,
	// command [1:0]
	input  wire logic [OP_W-1:0]     s_axis_tuser,
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	// status [2:0], found [3], entry_count [10:4], zero fill [15:11]
	output logic [M_DATA_W-1:0]      m_axis_tdata
);

	dp_cmd_t            cmd;
	dp_stat_t           stat;
	op_t                in_op;
	status_t            out_status;
	logic               out_found;
	logic [COUNT_W-1:0] out_count;

	assign in_op = op_t'(s_axis_tuser);

	crdt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_op   (in_op),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	crdt_dpath #(
		.ENTRIES(ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_op     (in_op),
		.in_owner  (s_axis_tdata[OWNER_W-1:0]),
		.in_cmd_id (s_axis_tdata[OWNER_W +: CMDID_W]),
		.in_tick   (s_axis_tdata[OWNER_W+CMDID_W +: TICK_W]),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_status(out_status),
		.out_found (out_found),
		.out_count (out_count)
	);

	// pack the result transfer
	assign m_axis_tdata = {{(M_DATA_W - STATUS_W - 1 - COUNT_W){1'b0}},
		out_count, out_found, out_status};

endmodule

`default_nettype wire

/* rtl/crdt_ram.sv */
// generic simple dual-port ram with registered read
// no dependencies; holds the replay table rows
`default_nettype none

module crdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/crdt_dpath.sv */
// datapath of the replay table: item registers, scan counter, table ram, count, result
// depends on crdt_pkg and crdt_ram
`default_nettype none

module crdt_dpath import crdt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dp_cmd_t             cmd,
	output dp_stat_t                 stat,
	input  wire op_t                 in_op,
	input  wire logic [OWNER_W-1:0]  in_owner,
	input  wire logic [CMDID_W-1:0]  in_cmd_id,
	input  wire logic [TICK_W-1:0]   in_tick,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output status_t                  out_status,
	output logic                     out_found,
	output logic [COUNT_W-1:0]       out_count
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] LAST_CNT = CW'(ENTRIES - 1);
	localparam logic [CW-1:0] END_CNT  = CW'(ENTRIES);
	localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

	op_t                op_q;
	logic [OWNER_W-1:0] owner_q;
	logic [CMDID_W-1:0] cmd_id_q;
	logic [TICK_W-1:0]  tick_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      held_q;
	logic               rv_s1;
	logic [AW-1:0]      idx_s1;
	logic               dup_q;
	logic               free_vld_q;
	logic [AW-1:0]      free_idx_q;
	logic               out_valid_q;
	status_t            out_status_q;
	logic               out_found_q;
	logic [COUNT_W-1:0] out_count_q;

	logic               issue;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	entry_t             wr_entry;
	logic [ENTRY_W-1:0] rd_data;
	entry_t             rd_e;
	logic               hit;
	logic               stale;
	logic               id_absent;
	status_t            resp_status;

	crdt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en  (issue),
		.rd_addr(cnt_q[AW-1:0]),
		.rd_data(rd_data)
	);

	// entry compare on the row read last cycle
	always_comb begin
		issue     = cmd.scan_en && (cnt_q != END_CNT);
		rd_e      = entry_t'(rd_data);
		hit       = rv_s1 && rd_e.valid && (rd_e.owner == owner_q) && (rd_e.cmd_id == cmd_id_q);
		stale     = rv_s1 && (op_q == OP_EXPIRE) && rd_e.valid && (rd_e.tick < tick_q);
		id_absent = (owner_q == '0) || (cmd_id_q == '0);
	end

	// table write: clearing sweep, new record or expired row
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = idx_s1;
		wr_entry = '0;
		if (cmd.sweep_en) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q[AW-1:0];
		end else if (cmd.write_new) begin
			wr_en    = 1'b1;
			wr_addr  = free_idx_q;
			wr_entry = '{valid: 1'b1, tick: tick_q, cmd_id: cmd_id_q, owner: owner_q};
		end else if (stale) begin
			wr_en = 1'b1;
		end
	end

	// result code of the finished operation
	always_comb begin
		resp_status = ST_DONE;
		if (op_q == OP_REMEMBER) begin
			if (id_absent) begin
				resp_status = ST_INVALID;
			end else if (dup_q) begin
				resp_status = ST_DUPLICATE;
			end else if (free_vld_q) begin
				resp_status = ST_RECORDED;
			end else begin
				resp_status = ST_FULL;
			end
		end
	end

	// item fields captured on the input transfer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_op;
			owner_q  <= in_owner;
			cmd_id_q <= in_cmd_id;
			tick_q   <= in_tick;
		end
	end

	// scan and sweep address counter, read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rv_s1 <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (issue || cmd.sweep_en) begin
				cnt_q <= cnt_q + CW'(1);
			end
			rv_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[AW-1:0];
	end

	// duplicate and first free slot tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_q      <= 1'b0;
			free_vld_q <= 1'b0;
		end else if (cmd.load) begin
			dup_q      <= 1'b0;
			free_vld_q <= 1'b0;
		end else begin
			if (hit) begin
				dup_q <= 1'b1;
			end
			if (rv_s1 && !rd_e.valid && !free_vld_q) begin
				free_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rv_s1 && !rd_e.valid && !free_vld_q) begin
			free_idx_q <= idx_s1;
		end
	end

	// held entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd.sweep_en) begin
			held_q <= '0;
		end else if (cmd.write_new) begin
			held_q <= held_q + CW'(1);
		end else if (stale && (held_q != '0)) begin
			held_q <= held_q - CW'(1);
		end
	end

	// output register, refilled once the previous result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.respond) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			out_status_q <= resp_status;
			out_found_q  <= (op_q == OP_CONTAINS) && dup_q && !id_absent;
			out_count_q  <= COUNT_W'(held_q);
		end
	end

	// status back to the controller, including the compare on the last row
	always_comb begin
		stat.op         = op_q;
		stat.id_absent  = id_absent;
		stat.dup        = dup_q || hit;
		stat.free_found = free_vld_q || (rv_s1 && !rd_e.valid);
		stat.scan_done  = rv_s1 && (idx_s1 == LAST_IDX);
		stat.sweep_done = (cnt_q == LAST_CNT);
		stat.out_busy   = out_valid_q && !out_ready;
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_found  = out_found_q;
	assign out_count  = out_count_q;

endmodule

`default_nettype wire

/* rtl/crdt_ctrl.sv */
// controller state machine of the replay table
// depends on crdt_pkg; drives the datapath through dp_cmd_t
`default_nettype none

module crdt_ctrl import crdt_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire op_t      in_op,
	output logic          in_ready,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			CS_INIT: begin
				cmd.sweep_en = 1'b1;
				if (stat.sweep_done) begin
					state_d = CS_IDLE;
				end
			end
			CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = (in_op == OP_CLEAR) ? CS_CLEAR : CS_SCAN;
				end
			end
			CS_SCAN: begin
				cmd.scan_en = 1'b1;
				if (stat.scan_done) begin
					if ((stat.op == OP_REMEMBER) && !stat.id_absent && !stat.dup
							&& stat.free_found) begin
						state_d = CS_WRITE;
					end else begin
						state_d = CS_RESP;
					end
				end
			end
			CS_CLEAR: begin
				cmd.sweep_en = 1'b1;
				if (stat.sweep_done) begin
					state_d = CS_RESP;
				end
			end
			CS_WRITE: begin
				cmd.write_new = 1'b1;
				state_d       = CS_RESP;
			end
			CS_RESP: begin
				if (!stat.out_busy) begin
					cmd.respond = 1'b1;
					state_d     = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_INIT;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/crdt_checker.sv */
// port-level checks of the command replay dedup table, bound to the top level
// depends on crdt_pkg and command_replay_dedup_table_macros.svh
`default_nettype none
`include "command_replay_dedup_table_macros.svh"

module crdt_checker import crdt_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_axis_tvalid,
	input wire logic                s_axis_tready,
	input wire logic [S_DATA_W-1:0] s_axis_tdata,
	input wire logic [OP_W-1:0]     s_axis_tuser,
	input wire logic                m_axis_tvalid,
	input wire logic                m_axis_tready,
	input wire logic [M_DATA_W-1:0] m_axis_tdata
);

	// a result waiting for the sink stays offered
	`CRDT_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

	// one command at a time: ready drops after every input transfer
	`CRDT_ASSERT_NXT(a_one_at_a_time, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// a positive lookup only comes with a done status
	`CRDT_ASSERT_IMP(a_found_done, clk, arst_n, m_axis_tvalid && m_axis_tdata[3], m_axis_tdata[2:0] == ST_DONE)

	// reported count never exceeds the table size
	`CRDT_ASSERT_IMP(a_count_range, clk, arst_n, m_axis_tvalid, int'(m_axis_tdata[10:4]) <= ENTRIES)

endmodule

bind command_replay_dedup_table crdt_checker #(
	.ENTRIES(ENTRIES)
) u_crdt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
